@@ rtl/obsm_pkg.sv @@
// Package for the order book side matcher: item types, codes and sizes.
// Depends on nothing; every other file of the block imports it.
package obsm_pkg;

   localparam int BOOK_DEPTH = 16;
   localparam int IDX_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int CQ_PTR_W = $clog2(CMD_QUEUE_DEPTH);
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int RQ_PTR_W = $clog2(RSP_QUEUE_DEPTH);

   localparam logic [1:0] MODE_MATCH  = 2'd0;
   localparam logic [1:0] MODE_ADD    = 2'd1;
   localparam logic [1:0] MODE_CANCEL = 2'd2;

   localparam logic [2:0] EV_EXEC          = 3'd0;
   localparam logic [2:0] EV_MATCH_DONE    = 3'd1;
   localparam logic [2:0] EV_ADDED         = 3'd2;
   localparam logic [2:0] EV_ADD_FULL      = 3'd3;
   localparam logic [2:0] EV_CANCEL_OK     = 3'd4;
   localparam logic [2:0] EV_CANCEL_REJECT = 3'd5;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] txn_id;
      logic [31:0] limit_price;
      logic [31:0] quantity;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [31:0] resting_id;
      logic [31:0] active_id;
      logic [31:0] exec_number;
      logic [31:0] trade_price;
      logic [31:0] trade_quantity;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_MATCH  = 2'd0,
      OP_ADD    = 2'd1,
      OP_CANCEL = 2'd2
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] txn_id;
      logic [31:0] limit_price;
      logic [31:0] quantity;
   } cmd_type;

endpackage

@@ rtl/obsm_front.sv @@
// Front end of the order book side matcher: takes requests and classifies them.
// Depends on obsm_pkg; feeds obsm_cmd_queue.
module obsm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  obsm_pkg::req_type req_data,
   input  logic             q_full,
   output logic             q_push,
   output obsm_pkg::cmd_type q_cmd
);
   import obsm_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   req_type hold_ff, hold_in;
   logic    drop;
   logic    release_item;
   logic    accept;

   // Unused modes and empty adds cause no result and go no further.
   assign drop = (hold_ff.mode != MODE_MATCH && hold_ff.mode != MODE_ADD &&
                  hold_ff.mode != MODE_CANCEL) ||
                 (hold_ff.mode == MODE_ADD && hold_ff.quantity == 32'd0);
   assign release_item = hold_valid_ff && (drop || !q_full);
   assign q_push = hold_valid_ff && !drop && !q_full;
   assign req_full = hold_valid_ff;
   assign accept = req_push && !hold_valid_ff;

   always_comb begin
      q_cmd.op = OP_MATCH;
      case (hold_ff.mode)
         MODE_ADD:    q_cmd.op = OP_ADD;
         MODE_CANCEL: q_cmd.op = OP_CANCEL;
         default:     q_cmd.op = OP_MATCH;
      endcase
      q_cmd.txn_id = hold_ff.txn_id;
      q_cmd.limit_price = hold_ff.limit_price;
      q_cmd.quantity = hold_ff.quantity;
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in = hold_ff;
      if (release_item) hold_valid_in = 1'b0;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_in = req_data;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (reset) hold_valid_ff <= 1'b0;
      else hold_valid_ff <= hold_valid_in;
   end

endmodule

@@ rtl/obsm_cmd_queue.sv @@
// Short command queue between the front end and the matching engine.
// Depends on obsm_pkg.
module obsm_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  obsm_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output obsm_pkg::cmd_type head
);
   import obsm_pkg::*;

   cmd_type             mem_ff [CMD_QUEUE_DEPTH];
   logic [CQ_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CQ_PTR_W:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full = (cnt_ff == (CQ_PTR_W+1)'(CMD_QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_in = wr_ff + CQ_PTR_W'(do_push);
      rd_in = rd_ff + CQ_PTR_W'(do_pop);
      cnt_in = cnt_ff + (CQ_PTR_W+1)'(do_push) - (CQ_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_cmd;
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ rtl/obsm_engine.sv @@
// Matching engine: holds the book, scans it one entry a cycle and queues results.
// Depends on obsm_pkg; takes commands from obsm_cmd_queue.
module obsm_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_wdata,
   input  logic              cmd_empty,
   input  obsm_pkg::cmd_type cmd_head,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output obsm_pkg::rsp_type rsp_data
);
   import obsm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic             side_ff, side_in;
   logic [31:0]      arrival_ff, arrival_in;
   logic [BOOK_DEPTH-1:0] valid_ff, valid_in;
   logic [31:0]      ent_id_ff    [BOOK_DEPTH];
   logic [31:0]      ent_price_ff [BOOK_DEPTH];
   logic [31:0]      ent_qty_ff   [BOOK_DEPTH];
   logic [31:0]      ent_exn_ff   [BOOK_DEPTH];
   logic [31:0]      ent_arr_ff   [BOOK_DEPTH];

   op_type           op_ff, op_in;
   logic [31:0]      id_ff, id_in, price_ff, price_in, qty_ff, qty_in;
   logic [IDX_W-1:0] idx_ff, idx_in, best_idx_ff, best_idx_in;
   logic             found_ff, found_in, cont_ff, cont_in;
   logic [31:0]      best_price_ff, best_price_in, best_age_ff, best_age_in;
   logic [31:0]      best_id_ff, best_id_in, best_qty_ff, best_qty_in;
   logic [31:0]      best_exn_ff, best_exn_in;
   rsp_type          res_ff, res_in;

   rsp_type             oq_ff [RSP_QUEUE_DEPTH];
   logic [RQ_PTR_W-1:0] owr_ff, ord_ff;
   logic [RQ_PTR_W:0]   ocnt_ff;
   logic                opush, opop, ofull;

   logic [31:0]      cur_age, fill, rest_qty;
   logic             cand, better, crosses;
   logic [IDX_W-1:0] free_slot;
   logic             has_free;
   logic             wr_add, wr_fill;

   assign ofull = (ocnt_ff == (RQ_PTR_W+1)'(RSP_QUEUE_DEPTH));
   assign opush = (state_ff == ST_EMIT) && !ofull;
   assign opop = rsp_pop && !rsp_empty;
   assign rsp_empty = (ocnt_ff == '0);
   assign rsp_data = oq_ff[ord_ff];
   assign cmd_pop = (state_ff == ST_IDLE) && !cmd_empty;

   // Age is measured against the current arrival count so wrapping is harmless.
   assign cur_age = arrival_ff - ent_arr_ff[idx_ff];
   always_comb begin
      if (ent_price_ff[idx_ff] != best_price_ff)
         better = side_ff ? (ent_price_ff[idx_ff] < best_price_ff)
                          : (ent_price_ff[idx_ff] > best_price_ff);
      else
         better = cur_age > best_age_ff;
      cand = valid_ff[idx_ff] &&
             (op_ff != OP_CANCEL || ent_id_ff[idx_ff] == id_ff) &&
             (!found_ff || better);
   end

   assign crosses = side_ff ? !(price_ff < best_price_ff) : !(price_ff > best_price_ff);
   assign fill = (qty_ff < best_qty_ff) ? qty_ff : best_qty_ff;
   assign rest_qty = best_qty_ff - fill;

   always_comb begin
      free_slot = '0;
      has_free = 1'b0;
      for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = IDX_W'(i);
            has_free = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      side_in = csr_we ? csr_wdata : side_ff;
      arrival_in = arrival_ff;
      valid_in = valid_ff;
      op_in = op_ff;
      id_in = id_ff;
      price_in = price_ff;
      qty_in = qty_ff;
      idx_in = idx_ff;
      best_idx_in = best_idx_ff;
      found_in = found_ff;
      cont_in = cont_ff;
      best_price_in = best_price_ff;
      best_age_in = best_age_ff;
      best_id_in = best_id_ff;
      best_qty_in = best_qty_ff;
      best_exn_in = best_exn_ff;
      res_in = res_ff;
      wr_add = 1'b0;
      wr_fill = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               op_in = cmd_head.op;
               id_in = cmd_head.txn_id;
               price_in = cmd_head.limit_price;
               qty_in = cmd_head.quantity;
               idx_in = '0;
               found_in = 1'b0;
               cont_in = 1'b0;
               res_in = '0;
               res_in.active_id = cmd_head.txn_id;
               res_in.last = 1'b1;
               if (cmd_head.op == OP_ADD) begin
                  res_in.trade_price = cmd_head.limit_price;
                  res_in.trade_quantity = cmd_head.quantity;
                  if (has_free) begin
                     wr_add = 1'b1;
                     valid_in[free_slot] = 1'b1;
                     arrival_in = arrival_ff + 32'd1;
                     res_in.event_kind = EV_ADDED;
                  end else begin
                     res_in.event_kind = EV_ADD_FULL;
                  end
                  state_in = ST_EMIT;
               end else if (cmd_head.op == OP_MATCH && cmd_head.quantity == 32'd0) begin
                  res_in.event_kind = EV_MATCH_DONE;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (cand) begin
               found_in = 1'b1;
               best_idx_in = idx_ff;
               best_price_in = ent_price_ff[idx_ff];
               best_age_in = cur_age;
               best_id_in = ent_id_ff[idx_ff];
               best_qty_in = ent_qty_ff[idx_ff];
               best_exn_in = ent_exn_ff[idx_ff];
            end
            if (idx_ff == IDX_W'(BOOK_DEPTH - 1)) state_in = ST_DECIDE;
            else idx_in = idx_ff + IDX_W'(1);
         end
         ST_DECIDE: begin
            res_in = '0;
            res_in.active_id = id_ff;
            cont_in = 1'b0;
            state_in = ST_EMIT;
            if (op_ff == OP_CANCEL) begin
               res_in.last = 1'b1;
               if (found_ff) begin
                  valid_in[best_idx_ff] = 1'b0;
                  res_in.event_kind = EV_CANCEL_OK;
               end else begin
                  res_in.event_kind = EV_CANCEL_REJECT;
               end
            end else if (found_ff && crosses) begin
               wr_fill = 1'b1;
               if (rest_qty == 32'd0) valid_in[best_idx_ff] = 1'b0;
               qty_in = qty_ff - fill;
               cont_in = 1'b1;
               res_in.event_kind = EV_EXEC;
               res_in.resting_id = best_id_ff;
               res_in.exec_number = best_exn_ff;
               res_in.trade_price = best_price_ff;
               res_in.trade_quantity = fill;
            end else begin
               res_in.event_kind = EV_MATCH_DONE;
               res_in.trade_quantity = qty_ff;
               res_in.last = 1'b1;
            end
         end
         ST_EMIT: begin
            if (!ofull) begin
               if (cont_ff) begin
                  // After an execution either the order is used up or the book is searched again.
                  if (qty_ff == 32'd0) begin
                     res_in = '0;
                     res_in.event_kind = EV_MATCH_DONE;
                     res_in.active_id = id_ff;
                     res_in.last = 1'b1;
                     cont_in = 1'b0;
                  end else begin
                     idx_in = '0;
                     found_in = 1'b0;
                     state_in = ST_SCAN;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_add) begin
         ent_id_ff[free_slot] <= id_in;
         ent_price_ff[free_slot] <= price_in;
         ent_qty_ff[free_slot] <= qty_in;
         ent_exn_ff[free_slot] <= 32'd1;
         ent_arr_ff[free_slot] <= arrival_ff;
      end
      if (wr_fill) begin
         ent_qty_ff[best_idx_ff] <= rest_qty;
         ent_exn_ff[best_idx_ff] <= best_exn_ff + 32'd1;
      end
      if (opush) oq_ff[owr_ff] <= res_ff;
      op_ff <= op_in;
      id_ff <= id_in;
      price_ff <= price_in;
      qty_ff <= qty_in;
      idx_ff <= idx_in;
      best_idx_ff <= best_idx_in;
      best_price_ff <= best_price_in;
      best_age_ff <= best_age_in;
      best_id_ff <= best_id_in;
      best_qty_ff <= best_qty_in;
      best_exn_ff <= best_exn_in;
      res_ff <= res_in;
      found_ff <= found_in;
      cont_ff <= cont_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         side_ff <= 1'b0;
         arrival_ff <= '0;
         valid_ff <= '0;
         owr_ff <= '0;
         ord_ff <= '0;
         ocnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         side_ff <= side_in;
         arrival_ff <= arrival_in;
         valid_ff <= valid_in;
         owr_ff <= owr_ff + RQ_PTR_W'(opush);
         ord_ff <= ord_ff + RQ_PTR_W'(opop);
         ocnt_ff <= ocnt_ff + (RQ_PTR_W+1)'(opush) - (RQ_PTR_W+1)'(opop);
      end
   end

endmodule

@@ rtl/order_book_side_matcher_top.sv @@
// One side of a price-time priority order book. A request reaches the engine through
// the front stage and the command queue. The engine reads one book entry per cycle when
// it searches for the best or the named order; a full result queue stalls the engine. A
// front stage and a short command queue take requests while the engine works, and a
// four-entry result queue holds results until they are transferred.
// Depends on obsm_pkg, obsm_front, obsm_cmd_queue and obsm_engine.
module order_book_side_matcher_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  obsm_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output obsm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_wdata
);
   import obsm_pkg::*;

   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_cmd, q_head;

   obsm_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .q_full(q_full), .q_push(q_push), .q_cmd(q_cmd)
   );

   obsm_cmd_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_cmd(q_cmd), .full(q_full),
      .pop(q_pop), .empty(q_empty), .head(q_head)
   );

   obsm_engine u_engine (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .cmd_empty(q_empty), .cmd_head(q_head), .cmd_pop(q_pop),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

endmodule

@@ tb/order_book_side_matcher_top_test.sv @@
// Self-checking testbench for order_book_side_matcher_top: queue-style request and result
// channels, a predicted order book, and comparison of each whole result.
// Depends on obsm_pkg and the order_book_side_matcher_top RTL.
`timescale 1ns / 1ps

module order_book_side_matcher_top_test;
   import obsm_pkg::*;

   localparam int DEPTH = BOOK_DEPTH;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_wdata = 1'b0;

   order_book_side_matcher_top DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Predicted book contents.
   logic        side_sell;
   logic        bk_valid [DEPTH];
   logic [31:0] bk_id [DEPTH];
   logic [31:0] bk_price [DEPTH];
   logic [31:0] bk_qty [DEPTH];
   logic [31:0] bk_exec [DEPTH];
   logic [31:0] bk_arrival [DEPTH];
   logic [31:0] arrival_count;

   req_type pending_orders[$];
   rsp_type expected_events[$];
   int      mismatches = 0;
   int      events_seen = 0;
   int      orders_sent = 0;
   int      cycle_count = 0;
   int      push_wait = 0;
   int      pop_wait = 0;
   logic    req_full_at_edge = 1'b1;

   function automatic logic outranks(int a, int b);
      if (bk_price[a] != bk_price[b])
         return side_sell ? (bk_price[a] < bk_price[b]) : (bk_price[a] > bk_price[b]);
      return (arrival_count - bk_arrival[a]) > (arrival_count - bk_arrival[b]);
   endfunction

   function automatic int best_entry(logic by_id, logic [31:0] id);
      int best;
      best = -1;
      for (int i = 0; i < DEPTH; i++) begin
         if (bk_valid[i] && (!by_id || bk_id[i] == id)) begin
            if (best < 0 || outranks(i, best))
               best = i;
         end
      end
      return best;
   endfunction

   function automatic rsp_type make_event(logic [2:0] kind, logic [31:0] rid,
                                          logic [31:0] aid, logic [31:0] exn,
                                          logic [31:0] price, logic [31:0] qty);
      rsp_type r;
      r.event_kind = kind;
      r.resting_id = rid;
      r.active_id = aid;
      r.exec_number = exn;
      r.trade_price = price;
      r.trade_quantity = qty;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic predict_order(req_type o);
      rsp_type     evs[$];
      rsp_type     r;
      int          b;
      int          slot;
      logic [31:0] qty;
      logic [31:0] fill;
      qty = o.quantity;
      if (o.mode == MODE_MATCH) begin
         while (qty != 0) begin
            b = best_entry(1'b0, '0);
            if (b < 0) break;
            if (side_sell ? (o.limit_price < bk_price[b]) : (o.limit_price > bk_price[b]))
               break;
            fill = (qty < bk_qty[b]) ? qty : bk_qty[b];
            qty -= fill;
            evs.push_back(make_event(EV_EXEC, bk_id[b], o.txn_id, bk_exec[b],
                                     bk_price[b], fill));
            bk_qty[b] -= fill;
            if (bk_qty[b] == 0) bk_valid[b] = 1'b0;
            else bk_exec[b] += 1;
         end
         evs.push_back(make_event(EV_MATCH_DONE, '0, o.txn_id, '0, '0, qty));
      end else if (o.mode == MODE_ADD) begin
         if (qty == 0) return;
         slot = -1;
         for (int i = DEPTH - 1; i >= 0; i--)
            if (!bk_valid[i]) slot = i;
         if (slot < 0) begin
            evs.push_back(make_event(EV_ADD_FULL, '0, o.txn_id, '0, o.limit_price, qty));
         end else begin
            bk_valid[slot] = 1'b1;
            bk_id[slot] = o.txn_id;
            bk_price[slot] = o.limit_price;
            bk_qty[slot] = qty;
            bk_exec[slot] = 1;
            bk_arrival[slot] = arrival_count;
            arrival_count += 1;
            evs.push_back(make_event(EV_ADDED, '0, o.txn_id, '0, o.limit_price, qty));
         end
      end else if (o.mode == MODE_CANCEL) begin
         b = best_entry(1'b1, o.txn_id);
         if (b >= 0) begin
            bk_valid[b] = 1'b0;
            evs.push_back(make_event(EV_CANCEL_OK, '0, o.txn_id, '0, '0, '0));
         end else begin
            evs.push_back(make_event(EV_CANCEL_REJECT, '0, o.txn_id, '0, '0, '0));
         end
      end else begin
         return;
      end
      r = evs.pop_back();
      r.last = 1'b1;
      evs.push_back(r);
      foreach (evs[i]) expected_events.push_back(evs[i]);
   endtask

   // Driver: presents the oldest pending order after a random gap.
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (req_push && !req_full_at_edge) begin
         // Transfer happened at the last rising edge.
         push_wait <= $urandom_range(0, 12);
         req_push <= 1'b0;
      end else if (!req_push && pending_orders.size() != 0) begin
         if (push_wait == 0) begin
            req_data <= pending_orders[0];
            req_push <= 1'b1;
         end else begin
            push_wait <= push_wait - 1;
         end
      end
   end

   // Accepted orders are predicted at the rising edge of their transfer.
   always @(posedge clock) begin
      req_full_at_edge <= req_full;
      if (!reset && req_push && !req_full) begin
         predict_order(pending_orders.pop_front());
         orders_sent++;
      end
   end

   // Monitor: pops results after random stalls and checks them.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (rsp_pop) begin
         rsp_pop <= 1'b0;
         pop_wait <= $urandom_range(0, 12);
      end else if (pop_wait == 0) begin
         rsp_pop <= 1'b1;
      end else begin
         pop_wait <= pop_wait - 1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      if (!reset && rsp_pop && !rsp_empty) begin
         events_seen++;
         if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %p", rsp_data);
         end else begin
            want = expected_events.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("order_book_side_matcher_top verification failed");
         $finish;
      end
   end

   function automatic req_type make_order(logic [1:0] mode, logic [31:0] id,
                                          logic [31:0] price, logic [31:0] qty);
      req_type o;
      o.mode = mode;
      o.txn_id = id;
      o.limit_price = price;
      o.quantity = qty;
      return o;
   endfunction

   task automatic drain_and_settle();
      while (pending_orders.size() != 0 || req_push || expected_events.size() != 0)
         @(posedge clock);
      // Zero-quantity adds and ignored modes give nothing, so allow the engine to finish.
      repeat (200) @(posedge clock);
   endtask

   task automatic write_side(logic sell);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= sell;
      @(negedge clock);
      csr_we <= 1'b0;
      side_sell = sell;
   endtask

   function automatic logic [31:0] pick_price(logic [31:0] base);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return $urandom();
         default: return base + $urandom_range(0, 8);
      endcase
   endfunction

   function automatic logic [31:0] pick_qty();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return $urandom();
         default: return $urandom_range(1, 20);
      endcase
   endfunction

   task automatic random_phase(int count, logic [31:0] base);
      logic [31:0] id;
      int          pick;
      for (int n = 0; n < count; n++) begin
         id = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 24);
         pick = $urandom_range(0, 19);
         if (pick < 9)
            pending_orders.push_back(make_order(MODE_ADD, id, pick_price(base), pick_qty()));
         else if (pick < 15)
            pending_orders.push_back(make_order(MODE_MATCH, id, pick_price(base), pick_qty()));
         else if (pick < 19)
            pending_orders.push_back(make_order(MODE_CANCEL, id, '0, '0));
         else
            pending_orders.push_back(make_order(MODE_UNUSED, $urandom(), $urandom(),
                                                $urandom()));
      end
   endtask

   initial begin
      side_sell = 1'b0;
      arrival_count = '0;
      for (int i = 0; i < DEPTH; i++) begin
         bk_valid[i] = 1'b0;
         bk_id[i] = '0;
         bk_price[i] = '0;
         bk_qty[i] = '0;
         bk_exec[i] = '0;
         bk_arrival[i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed buy book: ties, partial fill, full book, cancels, unused mode.
      write_side(1'b0);
      pending_orders.push_back(make_order(MODE_MATCH, 32'd1, 32'd5, 32'd10));
      pending_orders.push_back(make_order(MODE_ADD, 32'd2, 32'd0, 32'd0));
      for (int i = 0; i < 17; i++)
         pending_orders.push_back(make_order(MODE_ADD, 32'd10 + i, (i == 3) ? '1 : 32'd100,
                                             (i == 5) ? '1 : 32'd3));
      pending_orders.push_back(make_order(MODE_CANCEL, 32'd12, '0, '0));
      pending_orders.push_back(make_order(MODE_CANCEL, 32'd999, '0, '0));
      pending_orders.push_back(make_order(MODE_MATCH, 32'd40, 32'd100, 32'd7));
      pending_orders.push_back(make_order(MODE_MATCH, '1, '0, '1));
      pending_orders.push_back(make_order(MODE_UNUSED, '1, '1, '1));
      pending_orders.push_back(make_order(MODE_MATCH, 32'd41, '1, 32'd0));
      drain_and_settle();

      write_side(1'b1);
      random_phase(48, 32'd1000);
      drain_and_settle();
      write_side(1'b0);
      random_phase(48, 32'hFFFF_FFF0);
      drain_and_settle();

      $display("Sent %0d orders over buy and sell settings; %0d results checked.",
               orders_sent, events_seen);
      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("order_book_side_matcher_top verification clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_events.size());
         $display("order_book_side_matcher_top verification failed");
      end
      $finish;
   end

endmodule
